// ----- rtl/core/ssim_pkg.sv -----
// Shared types and constants for the spiral scan index map unit.
`default_nettype none

package ssim_pkg;

  localparam int unsigned DIM_W       = 9;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned AREA_W      = 2 * DIM_W;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } dims_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             oor;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } walk_state_e;

  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_BOTTOM = 2'd2,
    SIDE_LEFT   = 2'd3
  } side_e;

endpackage

`default_nettype wire

// ----- rtl/core/ssim_front.sv -----
// Front end: accepts positions, flags out-of-range ones, forwards them to the queue.
`default_nettype none

module ssim_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ssim_pkg::dims_t              dims_i,
  input  wire logic                         start_i,
  input  wire logic [ssim_pkg::POS_W-1:0]   position_i,
  output logic                              busy_o,
  input  wire ssim_pkg::q_status_t          q_status_i,
  output logic                              q_push_o,
  output ssim_pkg::item_t                   q_item_o
);

  logic                             valid_q, valid_d;
  ssim_pkg::item_t                  item_q, item_d;
  logic [ssim_pkg::AREA_W-1:0]      area;
  logic                             accept;

  assign area     = ssim_pkg::AREA_W'(dims_i.rows) * ssim_pkg::AREA_W'(dims_i.cols);
  assign busy_o   = valid_q && q_status_i.full;
  assign accept   = start_i && !busy_o;
  assign q_push_o = valid_q && !q_status_i.full;
  assign q_item_o = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (q_push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d         = 1'b1;
      item_d.position = position_i;
      item_d.oor      = {{(ssim_pkg::AREA_W - ssim_pkg::POS_W){1'b0}}, position_i} >= area;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/ssim_fifo.sv -----
// Short register queue between the front end and the spiral walker.
`default_nettype none

module ssim_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire ssim_pkg::item_t      item_i,
  input  wire logic                 pop_i,
  output ssim_pkg::item_t           item_o,
  output ssim_pkg::q_status_t       status_o
);

  ssim_pkg::item_t                  mem_q [ssim_pkg::QUEUE_DEPTH];
  logic [ssim_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [ssim_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                             do_push, do_pop;

  assign status_o.full  = count_q == ssim_pkg::QCNT_W'(ssim_pkg::QUEUE_DEPTH);
  assign status_o.empty = count_q == '0;
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign item_o         = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ssim_walk.sv -----
// Back end: walks the spiral one side per cycle and drives the result beat.
`default_nettype none

module ssim_walk (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ssim_pkg::dims_t               dims_i,
  input  wire ssim_pkg::q_status_t           q_status_i,
  input  wire ssim_pkg::item_t               q_item_i,
  output logic                               q_pop_o,
  output logic                               done_o,
  output logic [ssim_pkg::COORD_W-1:0]       row_o,
  output logic [ssim_pkg::COORD_W-1:0]       column_o,
  output logic                               out_of_range_o
);

  localparam int unsigned CW = ssim_pkg::COORD_W;
  localparam int unsigned DW = ssim_pkg::DIM_W;
  localparam int unsigned PW = ssim_pkg::POS_W;

  ssim_pkg::walk_state_e   state_q, state_d;
  ssim_pkg::side_e         side_q, side_d;
  logic [PW-1:0]           p_q, p_d;
  logic [CW-1:0]           r_q, r_d;
  logic [DW-1:0]           h_q, h_d, w_q, w_d;
  logic                    done_q, done_d;
  logic [CW-1:0]           row_q, row_d, col_q, col_d;
  logic                    oor_q, oor_d;

  logic [DW-1:0]           sw, sh;
  logic                    p_lt_sw, p_lt_sh;
  logic [CW-1:0]           p8, h8, w8;

  assign sw      = w_q - 1'b1;
  assign sh      = h_q - 1'b1;
  assign p_lt_sw = p_q < {{(PW - DW){1'b0}}, sw};
  assign p_lt_sh = p_q < {{(PW - DW){1'b0}}, sh};
  assign p8      = p_q[CW-1:0];
  assign h8      = h_q[CW-1:0];
  assign w8      = w_q[CW-1:0];

  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    p_d     = p_q;
    r_d     = r_q;
    h_d     = h_q;
    w_d     = w_q;
    done_d  = 1'b0;
    row_d   = row_q;
    col_d   = col_q;
    oor_d   = oor_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      ssim_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          q_pop_o = 1'b1;
          if (q_item_i.oor) begin
            done_d = 1'b1;
            oor_d  = 1'b1;
            row_d  = '0;
            col_d  = '0;
          end else begin
            p_d     = q_item_i.position;
            r_d     = '0;
            h_d     = dims_i.rows;
            w_d     = dims_i.cols;
            side_d  = ssim_pkg::SIDE_TOP;
            state_d = ssim_pkg::ST_WALK;
          end
        end
      end
      ssim_pkg::ST_WALK: begin
        oor_d = 1'b0;
        unique case (side_q)
          ssim_pkg::SIDE_TOP: begin
            priority if (h_q == '0 || w_q == '0) begin
              done_d  = 1'b1;
              row_d   = '0;
              col_d   = '0;
              state_d = ssim_pkg::ST_IDLE;
            end else if (h_q == DW'(1)) begin
              done_d  = 1'b1;
              row_d   = r_q;
              col_d   = r_q + p8;
              state_d = ssim_pkg::ST_IDLE;
            end else if (w_q == DW'(1)) begin
              done_d  = 1'b1;
              row_d   = r_q + p8;
              col_d   = r_q;
              state_d = ssim_pkg::ST_IDLE;
            end else if (p_lt_sw) begin
              done_d  = 1'b1;
              row_d   = r_q;
              col_d   = r_q + p8;
              state_d = ssim_pkg::ST_IDLE;
            end else begin
              p_d    = p_q - {{(PW - DW){1'b0}}, sw};
              side_d = ssim_pkg::SIDE_RIGHT;
            end
          end
          ssim_pkg::SIDE_RIGHT: begin
            if (p_lt_sh) begin
              done_d  = 1'b1;
              row_d   = r_q + p8;
              col_d   = r_q + w8 - 1'b1;
              state_d = ssim_pkg::ST_IDLE;
            end else begin
              p_d    = p_q - {{(PW - DW){1'b0}}, sh};
              side_d = ssim_pkg::SIDE_BOTTOM;
            end
          end
          ssim_pkg::SIDE_BOTTOM: begin
            if (p_lt_sw) begin
              done_d  = 1'b1;
              row_d   = r_q + h8 - 1'b1;
              col_d   = r_q + w8 - 1'b1 - p8;
              state_d = ssim_pkg::ST_IDLE;
            end else begin
              p_d    = p_q - {{(PW - DW){1'b0}}, sw};
              side_d = ssim_pkg::SIDE_LEFT;
            end
          end
          ssim_pkg::SIDE_LEFT: begin
            if (p_lt_sh) begin
              done_d  = 1'b1;
              row_d   = r_q + h8 - 1'b1 - p8;
              col_d   = r_q;
              state_d = ssim_pkg::ST_IDLE;
            end else begin
              p_d    = p_q - {{(PW - DW){1'b0}}, sh};
              r_d    = r_q + 1'b1;
              h_d    = h_q - DW'(2);
              w_d    = w_q - DW'(2);
              side_d = ssim_pkg::SIDE_TOP;
            end
          end
          default: begin
            side_d = ssim_pkg::SIDE_TOP;
          end
        endcase
      end
      default: begin
        state_d = ssim_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssim_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    p_q    <= p_d;
    r_q    <= r_d;
    h_q    <= h_d;
    w_q    <= w_d;
    row_q  <= row_d;
    col_q  <= col_d;
    oor_q  <= oor_d;
  end

  assign done_o         = done_q;
  assign row_o          = row_q;
  assign column_o       = col_q;
  assign out_of_range_o = oor_q;

endmodule

`default_nettype wire

// ----- rtl/core/spiral_scan_index_map_unit.sv -----
// Top level of the clockwise spiral scan index map unit.
//
// Maps a position along a clockwise spiral over a row_count by column_count
// grid to its row and column. Issue a position with start_i while busy_o is
// low; the beat is taken at that edge. Each result appears for one cycle with
// done_o high, in issue order; the receiver cannot stall, so results are
// never held back. Out-of-range positions return zeros with out_of_range_o.
// Registers (write with cfg_we_i): index 0 row_count, index 1 column_count;
// zero reads as 1, values above MAX_DIM saturate. Write only while idle.
// A position passes the input register and the queue to the walker, which
// answers an out-of-range position from its idle state and otherwise walks
// the spiral; the walker handles one side per cycle and steps over fewer
// than 2*min(rows, cols) sides. The walker takes a new item from the queue
// only in its idle state, after the last one is done; an item behind others
// waits for them. A two-entry queue and an input register buffer the front.
// Reset clears the queue and controller and sets both dimensions to 1.
`default_nettype none

module spiral_scan_index_map_unit #(
  parameter int unsigned MAX_DIM = 256
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ssim_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ssim_pkg::DIM_W-1:0]         cfg_wdata_i,
  input  wire logic                               start_i,
  input  wire logic [ssim_pkg::POS_W-1:0]         position_i,
  output logic                                    busy_o,
  output logic                                    done_o,
  output logic [ssim_pkg::COORD_W-1:0]            row_o,
  output logic [ssim_pkg::COORD_W-1:0]            column_o,
  output logic                                    out_of_range_o
);

  localparam int unsigned REG_MAX = (1 << ssim_pkg::DIM_W) - 1;
  localparam int unsigned DIM_CAP = (MAX_DIM > REG_MAX) ? REG_MAX : MAX_DIM;
  localparam logic [ssim_pkg::DIM_W-1:0] DIM_LIMIT = ssim_pkg::DIM_W'(DIM_CAP);

  logic [ssim_pkg::DIM_W-1:0] row_count_q, column_count_q;
  ssim_pkg::dims_t            dims;
  ssim_pkg::q_status_t        q_status;
  ssim_pkg::item_t            push_item, pop_item;
  logic                       q_push, q_pop;

  function automatic logic [ssim_pkg::DIM_W-1:0] clamp_dim(
    input logic [ssim_pkg::DIM_W-1:0] v
  );
    logic [ssim_pkg::DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = ssim_pkg::DIM_W'(1);
    end else if (v > DIM_LIMIT) begin
      res = DIM_LIMIT;
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= ssim_pkg::DIM_W'(1);
      column_count_q <= ssim_pkg::DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssim_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_wdata_i;
        ssim_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign dims.rows = clamp_dim(row_count_q);
  assign dims.cols = clamp_dim(column_count_q);

  ssim_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dims_i     (dims),
    .start_i    (start_i),
    .position_i (position_i),
    .busy_o     (busy_o),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  ssim_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .item_i   (push_item),
    .pop_i    (q_pop),
    .item_o   (pop_item),
    .status_o (q_status)
  );

  ssim_walk u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dims_i         (dims),
    .q_status_i     (q_status),
    .q_item_i       (pop_item),
    .q_pop_o        (q_pop),
    .done_o         (done_o),
    .row_o          (row_o),
    .column_o       (column_o),
    .out_of_range_o (out_of_range_o)
  );

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (row_o == '0 && column_o == '0))
    else $error("out-of-range result carries nonzero coordinates");

  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> q_status.full)
    else $error("busy asserted while the queue has room");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("walker popped an empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("front pushed into a full queue");

endmodule

`default_nettype wire
